/* rtl/sorted_alarm_queue_timer_defines.svh */
// Assertion macros for the sorted alarm queue timer.
`ifndef SORTED_ALARM_QUEUE_TIMER_DEFINES_SVH
`define SORTED_ALARM_QUEUE_TIMER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define SAQT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SAQT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

/* rtl/saqt_pkg.sv */
`default_nettype none
package saqt_pkg;
   localparam int ALARMS_DEFAULT = 8;
   localparam int QUEUE_DEPTH = 8;
   localparam logic [31:0] FREQ_RESET = 32'd1000000;
   localparam logic [31:0] MS_CAP = 32'd4294967;
   localparam logic [31:0] US_PER_MS = 32'd1000;
   localparam logic [62:0] TICK_RECIP = 63'd4835703278458516699;

   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_STOP = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CONV,
      ST_INSERT,
      ST_SCAN,
      ST_EMIT,
      ST_REPORT
   } saqt_state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] us;
   } saqt_conv_cmd_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] ticks;
   } saqt_conv_rsp_type;
endpackage
`default_nettype wire

/* rtl/saqt_ticks.sv */
`default_nettype none
module saqt_ticks (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [31:0]                 freq_hz,
   input  wire saqt_pkg::saqt_conv_cmd_type cmd,
   output saqt_pkg::saqt_conv_rsp_type      rsp
);
   import saqt_pkg::*;

   localparam logic [2:0] STEP_PROD = 3'd0;
   localparam logic [2:0] STEP_LL = 3'd1;
   localparam logic [2:0] STEP_LH = 3'd2;
   localparam logic [2:0] STEP_HL = 3'd3;
   localparam logic [2:0] STEP_HH = 3'd4;
   localparam logic [2:0] STEP_DONE = 3'd5;

   logic        busy_ff, busy_in;
   logic [2:0]  step_ff, step_in;
   logic [31:0] us_ff, us_in;
   logic [63:0] x_ff, x_in;
   logic [65:0] acc_ff, acc_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [63:0] top;

   // x / 1000000 = ((x >> 6) * TICK_RECIP) >> 76, built from 32 by 32 partial products
   always_comb begin
      unique case (step_ff)
         STEP_PROD: begin
            mul_a = freq_hz;
            mul_b = us_ff;
         end
         STEP_LL: begin
            mul_a = x_ff[37:6];
            mul_b = TICK_RECIP[31:0];
         end
         STEP_LH: begin
            mul_a = x_ff[37:6];
            mul_b = {1'b0, TICK_RECIP[62:32]};
         end
         STEP_HL: begin
            mul_a = {6'd0, x_ff[63:38]};
            mul_b = TICK_RECIP[31:0];
         end
         default: begin
            mul_a = {6'd0, x_ff[63:38]};
            mul_b = {1'b0, TICK_RECIP[62:32]};
         end
      endcase
      prod = {32'd0, mul_a} * {32'd0, mul_b};
      top = 64'(acc_ff[65:32]) + prod;
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      us_in = us_ff;
      x_in = x_ff;
      acc_in = acc_ff;
      quo_in = quo_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         step_in = STEP_PROD;
         us_in = cmd.us;
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         unique case (step_ff)
            STEP_PROD: begin
               x_in = prod;
            end
            STEP_LL: begin
               acc_in = 66'(prod[63:32]);
            end
            STEP_LH, STEP_HL: begin
               acc_in = acc_ff + 66'(prod);
            end
            STEP_HH: begin
               quo_in = {12'd0, top[63:12]};
            end
            default: begin
               busy_in = 1'b0;
               step_in = step_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      us_ff <= us_in;
      x_ff <= x_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = busy_ff && (step_ff == STEP_DONE);
   assign rsp.ticks = quo_ff;
endmodule
`default_nettype wire

/* rtl/sorted_alarm_queue_timer.sv */
// Multi-alarm timer: a 64-bit tick counter and up to eight alarms held in a queue sorted by
// due count. Each request yields zero or more fired records followed by one report. A start
// runs the millisecond to tick conversion in the shared conversion unit, five passes through
// one 32 by 32 multiplier (the frequency times microseconds product and four partial products
// of a reciprocal multiply by one millionth) and one step to hand over, and then walks the
// queue to insert the alarm. A tick scans the queue and emits one record per due alarm, and
// each periodic alarm it fires costs one more conversion and insertion walk. Results wait in
// one output register; the block stalls while it is full.
`default_nettype none
`include "sorted_alarm_queue_timer_defines.svh"
module sorted_alarm_queue_timer #(
   parameter int ALARMS = saqt_pkg::ALARMS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [2:0]  req_alarm,
   input  wire logic [31:0] req_milliseconds,
   input  wire logic        req_periodic,
   input  wire logic [31:0] req_user_param,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic [2:0]       rsp_fired_alarm,
   output logic [31:0]      rsp_fired_param,
   output logic             rsp_status,
   output logic             rsp_armed,
   output logic [63:0]      rsp_remaining_ticks,
   output logic             rsp_last,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [1:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import saqt_pkg::*;

   localparam int SLOTS = (ALARMS < QUEUE_DEPTH) ? ALARMS : QUEUE_DEPTH;

   saqt_state_type state_ff, state_in;
   logic [1:0]  act_ff, act_in;
   logic [2:0]  alarm_ff, alarm_in;
   logic [31:0] ms_ff, ms_in;
   logic        per_ff, per_in;
   logic [31:0] par_ff, par_in;
   logic [2:0]  cur_ff, cur_in;
   logic [3:0]  p_ff, p_in;
   logic [7:0]  fired_ff, fired_in;
   logic        rearm_ff, rearm_in;
   logic        status_ff, status_in;
   logic [63:0] key_ff, key_in;
   logic [63:0] tick_ff, tick_in;
   logic [31:0] freq_ff, freq_in;
   logic [2:0]  order_ff [QUEUE_DEPTH];
   logic [2:0]  order_in [QUEUE_DEPTH];
   logic [3:0]  len_ff, len_in;
   logic [7:0]  queued_ff, queued_in;
   logic [7:0]  started_ff, started_in;
   logic [7:0]  periodic_ff, periodic_in;
   logic [63:0] due_ff [QUEUE_DEPTH];
   logic [31:0] period_ff [QUEUE_DEPTH];
   logic [31:0] saved_ff [QUEUE_DEPTH];

   logic        rsp_valid_ff;
   logic        rsp_kind_ff, rsp_status_ff, rsp_has_ff, rsp_last_ff;
   logic [2:0]  rsp_alarm_ff;
   logic [31:0] rsp_param_ff;
   logic [63:0] rsp_rem_ff;

   saqt_conv_cmd_type conv_cmd;
   saqt_conv_rsp_type conv_rsp;

   logic        slot_free, in_pool;
   logic        rm_en, ins_en, due_we, prm_we, load_fire, load_report;
   logic [2:0]  rm_pos, ins_pos, find_pos, rd_idx, c_idx;
   logic [63:0] rd_due, due_wdata, rep_rem;
   logic [31:0] ms_cap, us_new;

   saqt_ticks u_ticks (
      .clock   (clock),
      .reset   (reset),
      .freq_hz (freq_ff),
      .cmd     (conv_cmd),
      .rsp     (conv_rsp)
   );

   always_comb begin
      find_pos = '0;
      for (int q = QUEUE_DEPTH - 1; q >= 0; q--) begin
         if ((q < int'(len_ff)) && (order_ff[q] == alarm_ff)) begin
            find_pos = 3'(q);
         end
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign in_pool = int'(alarm_ff) < SLOTS;
   assign ms_cap = (ms_ff > MS_CAP) ? MS_CAP : ms_ff;
   assign us_new = ms_cap * US_PER_MS;
   assign c_idx = order_ff[p_ff[2:0]];
   assign rd_due = due_ff[rd_idx];
   assign rep_rem = (len_ff == 4'd0 || rd_due < tick_ff) ? 64'd0 : rd_due - tick_ff;
   assign freq_in = (psel && penable && pwrite && paddr == 2'd0) ? pwdata : freq_ff;

   always_comb begin
      state_in = state_ff;
      act_in = act_ff;
      alarm_in = alarm_ff;
      ms_in = ms_ff;
      per_in = per_ff;
      par_in = par_ff;
      cur_in = cur_ff;
      p_in = p_ff;
      fired_in = fired_ff;
      rearm_in = rearm_ff;
      status_in = status_ff;
      key_in = key_ff;
      tick_in = tick_ff;
      queued_in = queued_ff;
      started_in = started_ff;
      periodic_in = periodic_ff;
      conv_cmd = '0;
      rm_en = 1'b0;
      rm_pos = p_ff[2:0];
      ins_en = 1'b0;
      ins_pos = p_ff[2:0];
      due_we = 1'b0;
      due_wdata = '0;
      prm_we = 1'b0;
      load_fire = 1'b0;
      load_report = 1'b0;
      rd_idx = c_idx;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in = req_action;
               alarm_in = req_alarm;
               ms_in = req_milliseconds;
               per_in = req_periodic;
               par_in = req_user_param;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            status_in = 1'b0;
            state_in = ST_REPORT;
            unique case (act_ff)
               ACT_TICK: begin
                  tick_in = tick_ff + 64'd1;
                  fired_in = '0;
                  p_in = '0;
                  state_in = ST_SCAN;
               end
               ACT_START: begin
                  if (in_pool) begin
                     if (started_ff[alarm_ff] && queued_ff[alarm_ff]) begin
                        rm_en = 1'b1;
                        rm_pos = find_pos;
                        queued_in[alarm_ff] = 1'b0;
                     end
                     started_in[alarm_ff] = 1'b1;
                     periodic_in[alarm_ff] = per_ff;
                     prm_we = 1'b1;
                     conv_cmd.start = 1'b1;
                     conv_cmd.us = us_new;
                     cur_in = alarm_ff;
                     rearm_in = 1'b0;
                     state_in = ST_CONV;
                  end
               end
               ACT_STOP: begin
                  if (in_pool) begin
                     if (!started_ff[alarm_ff]) begin
                        status_in = 1'b1;
                     end else begin
                        started_in[alarm_ff] = 1'b0;
                        if (queued_ff[alarm_ff]) begin
                           rm_en = 1'b1;
                           rm_pos = find_pos;
                           queued_in[alarm_ff] = 1'b0;
                        end
                     end
                  end
               end
               default: begin
                  state_in = ST_REPORT;
               end
            endcase
         end
         ST_CONV: begin
            rd_idx = cur_ff;
            if (conv_rsp.done) begin
               due_wdata = rearm_ff ? rd_due + conv_rsp.ticks : conv_rsp.ticks + tick_ff;
               due_we = 1'b1;
               key_in = due_wdata;
               p_in = '0;
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            if (len_ff < 4'(QUEUE_DEPTH) && p_ff < len_ff && key_ff > rd_due) begin
               p_in = p_ff + 4'd1;
            end else begin
               if (len_ff < 4'(QUEUE_DEPTH)) begin
                  ins_en = 1'b1;
                  queued_in[cur_ff] = 1'b1;
               end
               p_in = '0;
               state_in = rearm_ff ? ST_SCAN : ST_REPORT;
            end
         end
         ST_SCAN: begin
            if (p_ff >= len_ff || rd_due > tick_ff) begin
               state_in = ST_REPORT;
            end else if (!fired_ff[c_idx]) begin
               rm_en = 1'b1;
               queued_in[c_idx] = 1'b0;
               fired_in[c_idx] = 1'b1;
               cur_in = c_idx;
               state_in = ST_EMIT;
            end else begin
               p_in = p_ff + 4'd1;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               load_fire = 1'b1;
               p_in = '0;
               if (periodic_ff[cur_ff] && started_ff[cur_ff]) begin
                  conv_cmd.start = 1'b1;
                  conv_cmd.us = period_ff[cur_ff];
                  rearm_in = 1'b1;
                  state_in = ST_CONV;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_REPORT: begin
            rd_idx = order_ff[0];
            if (slot_free) begin
               load_report = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      len_in = len_ff;
      for (int q = 0; q < QUEUE_DEPTH; q++) begin
         order_in[q] = order_ff[q];
         if (rm_en && q >= int'(rm_pos) && q < QUEUE_DEPTH - 1) begin
            order_in[q] = order_ff[q + 1];
         end
         if (ins_en) begin
            if (q == int'(ins_pos)) begin
               order_in[q] = cur_ff;
            end else if (q > int'(ins_pos)) begin
               order_in[q] = order_ff[q - 1];
            end
         end
      end
      if (rm_en) begin
         len_in = len_ff - 4'd1;
      end else if (ins_en) begin
         len_in = len_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tick_ff <= '0;
         freq_ff <= FREQ_RESET;
         len_ff <= '0;
         queued_ff <= '0;
         started_ff <= '0;
         periodic_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tick_ff <= tick_in;
         freq_ff <= freq_in;
         len_ff <= len_in;
         queued_ff <= queued_in;
         started_ff <= started_in;
         periodic_ff <= periodic_in;
         if (load_fire || load_report) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      act_ff <= act_in;
      alarm_ff <= alarm_in;
      ms_ff <= ms_in;
      per_ff <= per_in;
      par_ff <= par_in;
      cur_ff <= cur_in;
      p_ff <= p_in;
      fired_ff <= fired_in;
      rearm_ff <= rearm_in;
      status_ff <= status_in;
      key_ff <= key_in;
      order_ff <= order_in;
      if (due_we) begin
         due_ff[cur_ff] <= due_wdata;
      end
      if (prm_we) begin
         period_ff[alarm_ff] <= us_new;
         saved_ff[alarm_ff] <= par_ff;
      end
      if (load_fire) begin
         rsp_kind_ff <= 1'b0;
         rsp_alarm_ff <= cur_ff;
         rsp_param_ff <= saved_ff[cur_ff];
         rsp_status_ff <= 1'b0;
         rsp_has_ff <= 1'b0;
         rsp_rem_ff <= '0;
         rsp_last_ff <= 1'b0;
      end else if (load_report) begin
         rsp_kind_ff <= 1'b1;
         rsp_alarm_ff <= '0;
         rsp_param_ff <= '0;
         rsp_status_ff <= status_ff;
         rsp_has_ff <= len_ff != 4'd0;
         rsp_rem_ff <= rep_rem;
         rsp_last_ff <= 1'b1;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_fired_alarm = rsp_alarm_ff;
   assign rsp_fired_param = rsp_param_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_armed = rsp_has_ff;
   assign rsp_remaining_ticks = rsp_rem_ff;
   assign rsp_last = rsp_last_ff;
   assign prdata = (paddr == 2'd0) ? freq_ff : 32'd0;
   assign pready = 1'b1;

   `SAQT_ASSERT(a_len_bound, len_ff <= 4'(QUEUE_DEPTH), "queue length above depth")
   `SAQT_ASSERT(a_len_match, $countones(queued_ff) == int'(len_ff), "queued bits off")
   `SAQT_NEVER(a_load_full, (load_fire || load_report) && rsp_valid_ff && !rsp_ready, "overwrite")
   `SAQT_ASSERT(a_idle_conv, (state_ff == ST_IDLE) |-> !conv_rsp.busy, "conversion busy while idle")
endmodule
`default_nettype wire

/* bench/sorted_alarm_queue_timer_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module sorted_alarm_queue_timer_tb;
   import saqt_pkg::*;

   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam logic [1:0] ADDR_FREQ = 2'd0;
   localparam int DRAIN_CYCLES = 1000;

   typedef struct packed {
      logic        kind;
      logic [2:0]  alarm;
      logic [31:0] param;
      logic        status;
      logic        armed;
      logic [63:0] remaining;
      logic        last;
   } alarm_event_type;

   typedef struct {
      logic [1:0]  action;
      logic [2:0]  alarm;
      logic [31:0] ms;
      logic        periodic;
      logic [31:0] param;
      bit          typed;
      logic        status;
      logic        armed;
      logic [63:0] remaining;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_action = ACT_TICK;
   logic [2:0] req_alarm = '0;
   logic [31:0] req_milliseconds = '0;
   logic req_periodic = 1'b0;
   logic [31:0] req_user_param = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_kind;
   logic [2:0] rsp_fired_alarm;
   logic [31:0] rsp_fired_param;
   logic rsp_status;
   logic rsp_armed;
   logic [63:0] rsp_remaining_ticks;
   logic rsp_last;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   sorted_alarm_queue_timer DUT (.*);

   always #1 clock = ~clock;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatches = 0;
   alarm_event_type pending_events[$];

   logic [31:0] freq_model;
   logic [63:0] now_ticks;
   logic [63:0] due_at[8];
   logic [31:0] period_us[8];
   logic [31:0] param_at[8];
   bit is_periodic[8];
   bit is_started[8];
   bit is_queued[8];
   logic [2:0] order[8];
   int order_len;

   function automatic logic [63:0] us_to_ticks(logic [31:0] us);
      return ({32'b0, freq_model} * {32'b0, us}) / 64'd1000000;
   endfunction

   function void drop_alarm(int a);
      for (int p = 0; p < order_len; p++) begin
         if (order[p] == a) begin
            for (int q = p; q + 1 < order_len; q++) order[q] = order[q + 1];
            order_len--;
            break;
         end
      end
      is_queued[a] = 0;
   endfunction

   function void queue_alarm(int a);
      int p;
      p = 0;
      if (order_len >= 8) return;
      while (p < order_len && due_at[a] > due_at[order[p]]) p++;
      for (int q = order_len; q > p; q--) order[q] = order[q - 1];
      order[p] = a[2:0];
      order_len++;
      is_queued[a] = 1;
   endfunction

   function void predict_request(logic [1:0] action, logic [2:0] a, logic [31:0] ms,
                                 logic per, logic [31:0] par);
      alarm_event_type ev;
      logic status;
      logic [7:0] fired;
      int pick;
      logic [63:0] d;
      status = 1'b0;
      fired = '0;
      if (action == ACT_TICK) begin
         now_ticks++;
         while (1) begin
            pick = 8;
            for (int p = 0; p < order_len; p++) begin
               if (due_at[order[p]] > now_ticks) break;
               if (!fired[order[p]]) begin
                  pick = order[p];
                  break;
               end
            end
            if (pick == 8) break;
            drop_alarm(pick);
            fired[pick] = 1'b1;
            ev = '0;
            ev.alarm = pick[2:0];
            ev.param = param_at[pick];
            pending_events.push_back(ev);
            if (is_periodic[pick] && is_started[pick]) begin
               due_at[pick] += us_to_ticks(period_us[pick]);
               queue_alarm(pick);
            end
         end
      end else if (action == ACT_START) begin
         if (is_started[a] && is_queued[a]) drop_alarm(a);
         is_started[a] = 1;
         if (ms > MS_CAP) ms = MS_CAP;
         param_at[a] = par;
         is_periodic[a] = per;
         period_us[a] = ms * US_PER_MS;
         due_at[a] = us_to_ticks(period_us[a]) + now_ticks;
         queue_alarm(a);
      end else if (action == ACT_STOP) begin
         if (!is_started[a]) begin
            status = 1'b1;
         end else begin
            is_started[a] = 0;
            if (is_queued[a]) drop_alarm(a);
         end
      end
      ev = '0;
      ev.kind = 1'b1;
      ev.status = status;
      ev.last = 1'b1;
      if (order_len > 0) begin
         ev.armed = 1'b1;
         d = due_at[order[0]];
         ev.remaining = (d < now_ticks) ? 64'd0 : d - now_ticks;
      end
      pending_events.push_back(ev);
   endfunction

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      alarm_event_type got;
      alarm_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_kind, rsp_fired_alarm, rsp_fired_param, rsp_status, rsp_armed,
                 rsp_remaining_ticks, rsp_last};
         if (pending_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            want = pending_events.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   task automatic write_freq(logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= ADDR_FREQ;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      freq_model = value;
   endtask

   task automatic wait_idle();
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_request(logic [1:0] action, logic [2:0] a, logic [31:0] ms,
                               logic per, logic [31:0] par);
      req_valid <= 1'b1;
      req_action <= action;
      req_alarm <= a;
      req_milliseconds <= ms;
      req_periodic <= per;
      req_user_param <= par;
      do @(posedge clock); while (!req_ready);
      predict_request(action, a, ms, per, par);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic random_request();
      logic [1:0] action;
      logic [31:0] ms;
      int r;
      r = $urandom_range(99);
      action = (r < 50) ? ACT_TICK : (r < 80) ? ACT_START : (r < 95) ? ACT_STOP : ACT_NONE;
      r = $urandom_range(99);
      ms = (r < 30) ? 32'd0 : (r < 80) ? $urandom_range(1, 8) :
           (r < 90) ? $urandom_range(1000, 3000) : $urandom;
      send_request(action, 3'($urandom_range(7)), ms, 1'($urandom_range(1)), $urandom);
   endtask

   directed_row_type directed[20] = '{
      '{ACT_STOP,  3'd0, 32'd0,        1'b0, 32'd0,        1'b1, 1'b1, 1'b0, 64'd0},
      '{ACT_NONE,  3'd7, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b1, 1'b0, 1'b0, 64'd0},
      '{ACT_TICK,  3'd0, 32'd0,        1'b0, 32'd0,        1'b1, 1'b0, 1'b0, 64'd0},
      '{ACT_START, 3'd0, 32'd5,        1'b0, 32'h1234,     1'b1, 1'b0, 1'b1, 64'd5000},
      '{ACT_START, 3'd1, 32'hFFFFFFFF, 1'b0, 32'd0,        1'b0, 1'b0, 1'b0, 64'd0},
      '{ACT_START, 3'd1, 32'd0,        1'b1, 32'hFFFFFFFF, 1'b0, 1'b0, 1'b0, 64'd0},
      '{ACT_TICK,  3'd0, 32'd0,        1'b0, 32'd0,        1'b0, 1'b0, 1'b0, 64'd0},
      '{ACT_START, 3'd2, 32'd0,        1'b0, 32'h22,       1'b0, 1'b0, 1'b0, 64'd0},
      '{ACT_START, 3'd3, 32'd0,        1'b0, 32'h33,       1'b0, 1'b0, 1'b0, 64'd0},
      '{ACT_START, 3'd7, 32'd0,        1'b1, 32'h77,       1'b0, 1'b0, 1'b0, 64'd0},
      '{ACT_TICK,  3'd0, 32'd0,        1'b0, 32'd0,        1'b0, 1'b0, 1'b0, 64'd0},
      '{ACT_STOP,  3'd3, 32'd0,        1'b0, 32'd0,        1'b0, 1'b0, 1'b0, 64'd0},
      '{ACT_STOP,  3'd7, 32'd0,        1'b0, 32'd0,        1'b0, 1'b0, 1'b0, 64'd0},
      '{ACT_STOP,  3'd7, 32'd0,        1'b0, 32'd0,        1'b0, 1'b0, 1'b0, 64'd0},
      '{ACT_START, 3'd4, 32'd4294967,  1'b0, 32'd1,        1'b0, 1'b0, 1'b0, 64'd0},
      '{ACT_START, 3'd5, 32'd4294968,  1'b1, 32'd2,        1'b0, 1'b0, 1'b0, 64'd0},
      '{ACT_START, 3'd6, 32'd1,        1'b1, 32'h5A5A5A5A, 1'b0, 1'b0, 1'b0, 64'd0},
      '{ACT_TICK,  3'd0, 32'd0,        1'b0, 32'd0,        1'b0, 1'b0, 1'b0, 64'd0},
      '{ACT_STOP,  3'd1, 32'd0,        1'b0, 32'd0,        1'b0, 1'b0, 1'b0, 64'd0},
      '{ACT_TICK,  3'd0, 32'd0,        1'b0, 32'd0,        1'b0, 1'b0, 1'b0, 64'd0}
   };

   logic [31:0] phase_freq[4] = '{32'd1000, 32'd1, 32'd0, 32'hFFFFFFFF};
   int phase_idle[4] = '{0, 80, 0, 20};
   int phase_stall[4] = '{0, 0, 80, 20};

   initial begin
      freq_model = FREQ_RESET;
      now_ticks = '0;
      order_len = 0;
      for (int i = 0; i < 8; i++) begin
         is_periodic[i] = 0;
         is_started[i] = 0;
         is_queued[i] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         send_request(directed[i].action, directed[i].alarm, directed[i].ms,
                      directed[i].periodic, directed[i].param);
         if (directed[i].typed) begin
            pending_events[$].status = directed[i].status;
            pending_events[$].armed = directed[i].armed;
            pending_events[$].remaining = directed[i].remaining;
         end
      end
      for (int ph = 0; ph < 4; ph++) begin
         req_valid <= 1'b0;
         wait_idle();
         send_idle_pct = 0;
         recv_stall_pct = 0;
         write_freq(phase_freq[ph]);
         send_idle_pct = phase_idle[ph];
         recv_stall_pct = phase_stall[ph];
         for (int n = 0; n < 40; n++) begin
            if (ph == 1 && n == 20) begin
               req_valid <= 1'b0;
               while (pending_events.size() != 0) @(posedge clock);
            end
            random_request();
         end
      end
      req_valid <= 1'b0;
      recv_stall_pct = 0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("sorted_alarm_queue_timer_tb: done, clean");
      end else begin
         $display("sorted_alarm_queue_timer_tb: done, errors");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("sorted_alarm_queue_timer_tb: done, errors");
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/saqt_pkg.sv
rtl/saqt_ticks.sv
rtl/sorted_alarm_queue_timer.sv
bench/sorted_alarm_queue_timer_tb.sv
